[hw/rtl/swrh_pkg.sv]
// Shared types and constants for the stop-and-wait file receiver with DJB2 hash.
// No dependencies; imported by swrh_core and stop_and_wait_receiver_hash_top.
package swrh_pkg;

   localparam int HEADER_BYTES = 10;

   localparam logic [63:0] HASH_SEED        = 64'd5381;
   localparam logic [19:0] FILE_LIMIT_RESET = 20'd20000;

   localparam logic [15:0] STATUS_PROGRESS = 16'd0;
   localparam logic [15:0] STATUS_START    = 16'd1;
   localparam logic [15:0] STATUS_FIN      = 16'd2;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_BYTE   = 1'b1;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // csr word index
   localparam logic CSR_FILE_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      VERDICT_START       = 3'd0,
      VERDICT_APPENDED    = 3'd1,
      VERDICT_DUPLICATE   = 3'd2,
      VERDICT_OUT_OF_ORDER = 3'd3,
      VERDICT_NOT_STARTED = 3'd4,
      VERDICT_OVERFLOW    = 3'd5,
      VERDICT_UNKNOWN     = 3'd6
   } swrh_verdict_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] datagram_length;
      logic [15:0] payload_length;
      logic [31:0] sequence_number;
      logic [15:0] status_flag;
      logic [7:0]  data_byte;
   } swrh_item_type;

   // what one request produces: an optional ack, preceded by a report when a file completes
   typedef struct packed {
      logic        rpt_valid;
      logic        ack_valid;
      logic [31:0] ack_sequence;
      logic [2:0]  verdict;
      logic [19:0] total_bytes;
      logic [63:0] file_hash;
   } swrh_result_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] ack_sequence;
      logic [2:0]  verdict;
      logic [19:0] total_bytes;
      logic [63:0] file_hash;
      logic        last_of_run;
   } swrh_rsp_type;

endpackage

[hw/rtl/swrh_core.sv]
// Transfer state and per-request decision logic: sequence checks, limit check,
// DJB2 hash update and completion report. Depends on swrh_pkg.
module swrh_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_fire,
   input  swrh_pkg::swrh_item_type  item,
   input  logic [19:0]              file_limit,
   output swrh_pkg::swrh_result_type result
);
   import swrh_pkg::*;

   logic             started_ff, started_in;
   logic [31:0]      expected_ff, expected_in;
   logic [19:0]      count_ff, count_in;
   logic [63:0]      hash_ff, hash_in;
   logic [15:0]      remaining_ff, remaining_in;
   logic             append_ff, append_in;
   logic [2:0]       pverdict_ff, pverdict_in;
   logic [31:0]      psequence_ff, psequence_in;
   logic             pfinish_ff, pfinish_in;

   logic [63:0]      hash_step;
   logic [16:0]      header_span;
   logic [20:0]      count_sum;
   logic             fits;
   logic             finish;
   swrh_verdict_type verdict;

   // hash * 33 + byte
   assign hash_step   = (hash_ff << 5) + hash_ff + {56'd0, item.data_byte};
   assign header_span = {1'b0, item.payload_length} + 17'(HEADER_BYTES);
   assign count_sum   = {1'b0, count_ff} + {5'd0, item.payload_length};

   always_comb begin
      started_in   = started_ff;
      expected_in  = expected_ff;
      count_in     = count_ff;
      hash_in      = hash_ff;
      remaining_in = remaining_ff;
      append_in    = append_ff;
      pverdict_in  = pverdict_ff;
      psequence_in = psequence_ff;
      pfinish_in   = pfinish_ff;
      result       = '0;
      finish       = 1'b0;
      fits         = 1'b0;
      verdict      = VERDICT_START;

      if (item_fire) begin
         if (item.operation == OP_BYTE) begin
            if (remaining_ff != 16'd0) begin
               if (append_ff) begin
                  hash_in  = hash_step;
                  count_in = count_ff + 20'd1;
               end
               remaining_in = remaining_ff - 16'd1;
               finish       = (remaining_ff == 16'd1);
            end
         end else begin
            // a new header abandons any unfinished packet
            remaining_in = '0;
            append_in    = 1'b0;
            pfinish_in   = 1'b0;
            if (item.datagram_length >= 16'(HEADER_BYTES) &&
                header_span <= {1'b0, item.datagram_length}) begin
               case (item.status_flag)
                  STATUS_START: begin
                     started_in  = 1'b1;
                     expected_in = item.sequence_number;
                     count_in    = '0;
                     hash_in     = HASH_SEED;
                     fits        = ({4'd0, item.payload_length} <= file_limit);
                     append_in   = fits;
                     verdict     = fits ? VERDICT_START : VERDICT_OVERFLOW;
                  end
                  STATUS_PROGRESS, STATUS_FIN: begin
                     if (!started_ff) begin
                        verdict = VERDICT_NOT_STARTED;
                     end else if (item.sequence_number == expected_ff) begin
                        fits      = (count_sum <= {1'b0, file_limit});
                        append_in = fits;
                        verdict   = fits ? VERDICT_APPENDED : VERDICT_OVERFLOW;
                        if (item.status_flag == STATUS_FIN) begin
                           pfinish_in = 1'b1;
                        end else if (fits) begin
                           expected_in = expected_ff + 32'd1;
                        end
                     end else if (item.sequence_number < expected_ff) begin
                        verdict = VERDICT_DUPLICATE;
                     end else begin
                        verdict = VERDICT_OUT_OF_ORDER;
                     end
                  end
                  default: begin
                     verdict = VERDICT_UNKNOWN;
                  end
               endcase
               pverdict_in  = verdict;
               psequence_in = item.sequence_number;
               remaining_in = item.payload_length;
               finish       = (item.payload_length == 16'd0);
            end
         end

         if (finish) begin
            result.ack_valid    = 1'b1;
            result.ack_sequence = psequence_in;
            result.verdict      = pverdict_in;
            if (pfinish_in) begin
               result.rpt_valid   = 1'b1;
               result.total_bytes = count_in;
               result.file_hash   = hash_in;
               started_in         = 1'b0;
               expected_in        = '0;
               count_in           = '0;
               hash_in            = HASH_SEED;
            end
            pfinish_in = 1'b0;
            append_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         expected_ff  <= '0;
         count_ff     <= '0;
         hash_ff      <= HASH_SEED;
         remaining_ff <= '0;
         append_ff    <= 1'b0;
         pverdict_ff  <= '0;
         psequence_ff <= '0;
         pfinish_ff   <= 1'b0;
      end else begin
         started_ff   <= started_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         hash_ff      <= hash_in;
         remaining_ff <= remaining_in;
         append_ff    <= append_in;
         pverdict_ff  <= pverdict_in;
         psequence_ff <= psequence_in;
         pfinish_ff   <= pfinish_in;
      end
   end

   a_fin_needs_start: assert property (@(posedge clock) disable iff (reset)
      pfinish_ff |-> started_ff)
      else $error("pending FIN without an open transfer");

   a_append_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      append_ff |-> (remaining_ff != 16'd0))
      else $error("append enabled with no payload outstanding");

   a_report_has_ack: assert property (@(posedge clock) disable iff (reset)
      result.rpt_valid |-> result.ack_valid)
      else $error("report without acknowledgement");

endmodule

[hw/rtl/stop_and_wait_receiver_hash_top.sv]
// Requests pass the input register and swrh_core; results are registered before rsp.
// Throughput: one request per cycle unless rsp stalls or the ack slot is full; a request
// that completes a file gives two results (report, then ack), holding the next request
// while the ack waits. Rate set by the single output register plus one overflow slot
// for the trailing ack. Synchronous active-high reset clears all transfer state at once;
// no clearing pass. Depends on swrh_pkg and swrh_core.
module stop_and_wait_receiver_hash_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // datagram_length, payload_length, sequence_number,
                                     // status_flag, data_byte
   input  logic         req_tuser,   // operation
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // ack_sequence, verdict, total_bytes, file_hash, pad
   output logic         rsp_tuser,   // result_kind
   output logic         rsp_tlast,   // last_of_run
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import swrh_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   swrh_item_type   s1_item_ff;
   logic            s1_fire;
   logic            req_fire;

   swrh_rsp_type    out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   swrh_rsp_type    hold_ff, hold_in;
   logic            hold_valid_ff, hold_valid_in;
   logic            out_take;

   logic [19:0]     file_limit_ff;
   swrh_result_type result;
   swrh_rsp_type    ack_entry;
   swrh_rsp_type    rpt_entry;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FILE_LIMIT) ? {12'd0, file_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_limit_ff <= FILE_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == CSR_FILE_LIMIT) begin
         file_limit_ff <= csr_pwdata[19:0];
      end
   end

   // ---------------- input register ----------------
   assign out_take   = out_valid_ff && rsp_tready;
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready) && !hold_valid_ff;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.operation       <= req_tuser;
         s1_item_ff.datagram_length <= req_tdata[15:0];
         s1_item_ff.payload_length  <= req_tdata[31:16];
         s1_item_ff.sequence_number <= req_tdata[63:32];
         s1_item_ff.status_flag     <= req_tdata[79:64];
         s1_item_ff.data_byte       <= req_tdata[87:80];
      end
   end

   swrh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (s1_fire),
      .item       (s1_item_ff),
      .file_limit (file_limit_ff),
      .result     (result)
   );

   // ---------------- result register and ack slot ----------------
   always_comb begin
      ack_entry.result_kind  = KIND_ACK;
      ack_entry.ack_sequence = result.ack_sequence;
      ack_entry.verdict      = result.verdict;
      ack_entry.total_bytes  = '0;
      ack_entry.file_hash    = '0;
      ack_entry.last_of_run  = 1'b1;

      rpt_entry.result_kind  = KIND_REPORT;
      rpt_entry.ack_sequence = '0;
      rpt_entry.verdict      = '0;
      rpt_entry.total_bytes  = result.total_bytes;
      rpt_entry.file_hash    = result.file_hash;
      rpt_entry.last_of_run  = 1'b0;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (out_take) begin
         out_valid_in = 1'b0;
      end
      // the ack slot drains first; no request fires while it is full
      if (out_take && hold_valid_ff) begin
         out_in        = hold_ff;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end else if (result.rpt_valid) begin
         out_in        = rpt_entry;
         out_valid_in  = 1'b1;
         hold_in       = ack_entry;
         hold_valid_in = 1'b1;
      end else if (result.ack_valid) begin
         out_in       = ack_entry;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.result_kind;
   assign rsp_tlast  = out_ff.last_of_run;
   assign rsp_tdata  = {1'b0, out_ff.file_hash, out_ff.total_bytes, out_ff.verdict,
                        out_ff.ack_sequence};

   a_hold_behind_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (out_valid_ff && out_ff.result_kind == KIND_REPORT))
      else $error("ack slot full without a report in front");

   a_report_then_ack: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last_of_run) |-> hold_valid_ff)
      else $error("non-final result with no ack queued");

   a_no_fire_on_hold: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !s1_fire)
      else $error("request processed while ack slot full");

endmodule

[tb/sv/stop_and_wait_receiver_hash_top_test.sv]
// Self-checking testbench for stop_and_wait_receiver_hash_top: drives file transfers and noise
// on the request stream and checks every result against an internal transfer and hash predictor.
// Depends on swrh_pkg and the RTL of stop_and_wait_receiver_hash_top.
module stop_and_wait_receiver_hash_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import swrh_pkg::*;

   localparam logic [2:0] LIMIT_ADDR = {CSR_FILE_LIMIT, 2'b00};
   localparam int DRAIN_CYCLES = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   stop_and_wait_receiver_hash_top dut (.*);

   always #2 clock = ~clock;

   // predicted receiver state
   logic [19:0]      rx_limit;
   logic             rx_started;
   logic [31:0]      rx_expected;
   logic [19:0]      rx_count;
   logic [63:0]      rx_hash;
   logic [15:0]      rx_remaining;
   logic             rx_append;
   swrh_verdict_type rx_verdict;
   logic [31:0]      rx_seq;
   logic             rx_fin;

   swrh_rsp_type pending_results[$];
   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int holdoff_left = 0;
   int useful_requests = 0;

   task automatic clear_transfer();
      rx_started  = 1'b0;
      rx_expected = '0;
      rx_count    = '0;
      rx_hash     = HASH_SEED;
   endtask

   task automatic close_packet();
      swrh_rsp_type r;
      if (rx_fin) begin
         r = '{KIND_REPORT, 32'd0, 3'd0, rx_count, rx_hash, 1'b0};
         pending_results.push_back(r);
         clear_transfer();
      end
      r = '{KIND_ACK, rx_seq, rx_verdict, 20'd0, 64'd0, 1'b1};
      pending_results.push_back(r);
      rx_fin    = 1'b0;
      rx_append = 1'b0;
   endtask

   task automatic predict_request(swrh_item_type it);
      logic fits;
      if (it.operation == OP_BYTE) begin
         if (rx_remaining != 0) begin
            if (rx_append) begin
               rx_hash  = (rx_hash << 5) + rx_hash + 64'(it.data_byte);
               rx_count = rx_count + 20'd1;
            end
            rx_remaining = rx_remaining - 16'd1;
            if (rx_remaining == 0) close_packet();
         end
         return;
      end
      // a header abandons whatever packet is still open
      rx_remaining = '0;
      rx_append    = 1'b0;
      rx_fin       = 1'b0;
      if (it.datagram_length < HEADER_BYTES) return;
      if (HEADER_BYTES + int'(it.payload_length) > int'(it.datagram_length)) return;
      if (it.status_flag == STATUS_START) begin
         rx_started  = 1'b1;
         rx_expected = it.sequence_number;
         rx_count    = '0;
         rx_hash     = HASH_SEED;
         fits        = 20'(it.payload_length) <= rx_limit;
         rx_append   = fits;
         rx_verdict  = fits ? VERDICT_START : VERDICT_OVERFLOW;
      end else if (it.status_flag == STATUS_PROGRESS || it.status_flag == STATUS_FIN) begin
         if (!rx_started) begin
            rx_verdict = VERDICT_NOT_STARTED;
         end else if (it.sequence_number == rx_expected) begin
            fits       = 21'(rx_count) + 21'(it.payload_length) <= 21'(rx_limit);
            rx_append  = fits;
            rx_verdict = fits ? VERDICT_APPENDED : VERDICT_OVERFLOW;
            if (it.status_flag == STATUS_FIN) rx_fin = 1'b1;
            else if (fits) rx_expected = rx_expected + 32'd1;
         end else if (it.sequence_number < rx_expected) begin
            rx_verdict = VERDICT_DUPLICATE;
         end else begin
            rx_verdict = VERDICT_OUT_OF_ORDER;
         end
      end else begin
         rx_verdict = VERDICT_UNKNOWN;
      end
      rx_seq       = it.sequence_number;
      rx_remaining = it.payload_length;
      if (it.payload_length == 0) close_packet();
   endtask

   function automatic swrh_item_type random_item();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[88:0];
   endfunction

   // offer one request, hold it until accepted, then update the prediction
   task automatic send_item(swrh_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.operation;
      req_tdata  = {it.data_byte, it.status_flag, it.sequence_number,
                    it.payload_length, it.datagram_length};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_request(it);
   endtask

   task automatic send_header(logic [15:0] flag, logic [31:0] seq, logic [15:0] plen,
                              logic [15:0] dlen);
      swrh_item_type it;
      it = random_item();
      it.operation       = OP_HEADER;
      it.status_flag     = flag;
      it.sequence_number = seq;
      it.payload_length  = plen;
      it.datagram_length = dlen;
      send_item(it);
   endtask

   task automatic send_byte(logic [7:0] value);
      swrh_item_type it;
      it = random_item();
      it.operation = OP_BYTE;
      it.data_byte = value;
      send_item(it);
   endtask

   // well-formed header plus payload; cut_short leaves the payload unfinished
   task automatic send_packet(logic [15:0] flag, logic [31:0] seq, int plen, bit cut_short);
      logic [15:0] dlen;
      int n_bytes;
      dlen = ($urandom_range(0, 29) == 0) ? 16'hFFFF : 16'(HEADER_BYTES + plen + $urandom_range(0, 3));
      send_header(flag, seq, 16'(plen), dlen);
      n_bytes = (cut_short && plen > 0) ? $urandom_range(0, plen - 1) : plen;
      repeat (n_bytes) send_byte(8'($urandom));
      useful_requests += 1 + n_bytes;
   endtask

   task automatic idle_request();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_until_quiet();
      idle_request();
      while (pending_results.size() != 0) @(posedge clock);
      // a payload with no result left may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_limit(logic [19:0] value);
      wait_until_quiet();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = LIMIT_ADDR;
      csr_pwdata  = {12'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[19:0] !== value) begin
         $display("%0t ns: file_limit readback expected %0d actual %0d",
                  $time, value, csr_prdata[19:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      rx_limit = value;
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready = 1'b0;
         holdoff_left--;
      end else begin
         rsp_tready = $urandom_range(0, 99) >= receiver_idle_pct;
      end
   end

   always @(posedge clock) begin
      swrh_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none actual kind %0d seq %0h",
                     $time, rsp_tuser, rsp_tdata[31:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", 64'(want.result_kind), 64'(rsp_tuser));
            check_field("ack_sequence", 64'(want.ack_sequence), 64'(rsp_tdata[31:0]));
            check_field("verdict", 64'(want.verdict), 64'(rsp_tdata[34:32]));
            check_field("total_bytes", 64'(want.total_bytes), 64'(rsp_tdata[54:35]));
            check_field("file_hash", want.file_hash, rsp_tdata[118:55]);
            check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_tlast));
         end
      end
   end

   task automatic test_special_cases();
      send_header(STATUS_PROGRESS, 32'h1234_5678, 16'd0, 16'(HEADER_BYTES)); // before START
      send_header(STATUS_START, 32'd0, 16'd0, 16'(HEADER_BYTES - 1));       // short header
      send_header(STATUS_START, 32'd0, 16'hFFFF, 16'hFFFF);                 // malformed
      send_byte(8'h5A);                                                     // stray byte
      send_header(STATUS_START, 32'hFFFF_FFFF, 16'd2, 16'(HEADER_BYTES + 2));
      send_byte(8'hFF);
      send_byte(8'h00);
      send_header(STATUS_PROGRESS, 32'hFFFF_FFFF, 16'd1, 16'hFFFF);         // expected wraps
      send_byte(8'hA5);
      send_header(STATUS_PROGRESS, 32'd0, 16'd0, 16'(HEADER_BYTES));
      send_header(STATUS_FIN, 32'd0, 16'd0, 16'(HEADER_BYTES));             // duplicate
      send_header(STATUS_PROGRESS, 32'hFFFF_FFFF, 16'd0, 16'(HEADER_BYTES)); // out of order
      send_header(16'hFFFF, 32'd1, 16'd1, 16'(HEADER_BYTES + 1));           // unknown flag
      send_byte(8'h3C);
      send_header(STATUS_PROGRESS, 32'd1, 16'd3, 16'(HEADER_BYTES + 3));    // abandoned below
      send_byte(8'h11);
      send_byte(8'h22);
      send_header(STATUS_FIN, 32'd2, 16'd1, 16'(HEADER_BYTES + 1));
      send_byte(8'h81);
      send_header(STATUS_FIN, 32'd3, 16'd0, 16'(HEADER_BYTES));             // after reset of file
   endtask

   task automatic test_file_limit();
      csr_write_limit(20'd0);
      send_packet(STATUS_START, 32'd7, 1, 1'b0);
      send_packet(STATUS_START, 32'd7, 0, 1'b0);
      send_packet(STATUS_FIN, 32'd7, 0, 1'b0);
      csr_write_limit(20'd5);
      send_packet(STATUS_START, 32'd100, 3, 1'b0);
      send_packet(STATUS_PROGRESS, 32'd101, 3, 1'b0);
      send_packet(STATUS_PROGRESS, 32'd101, 2, 1'b0);
      send_packet(STATUS_FIN, 32'd102, 1, 1'b0);
      csr_write_limit(20'hFFFFF);
      send_packet(STATUS_START, 32'd0, 40, 1'b0);
      send_packet(STATUS_FIN, 32'd0, 20, 1'b0);
      csr_write_limit(FILE_LIMIT_RESET);
   endtask

   task automatic test_random_transfers(int n_requests);
      int goal;
      int pick;
      int plen;
      logic [31:0] seq;
      logic [15:0] flag;
      goal = useful_requests + n_requests;
      while (useful_requests < goal) begin
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(0, 6);
         if (pick < 60) begin
            if (!rx_started || $urandom_range(0, 11) == 0) begin
               case ($urandom_range(0, 3))
                  0: seq = 32'hFFFF_FFFF - $urandom_range(0, 3);
                  1: seq = 32'd0;
                  default: seq = $urandom;
               endcase
               flag = STATUS_START;
            end else begin
               seq  = rx_expected;
               flag = ($urandom_range(0, 6) == 0) ? STATUS_FIN : STATUS_PROGRESS;
            end
            send_packet(flag, seq, plen, $urandom_range(0, 24) == 0);
         end else if (pick < 72) begin
            case ($urandom_range(0, 2))
               0: seq = rx_expected - 32'd1 - $urandom_range(0, 3);
               1: seq = rx_expected + 32'd1 + $urandom_range(0, 3);
               default: seq = $urandom;
            endcase
            flag = $urandom_range(0, 1) ? STATUS_FIN : STATUS_PROGRESS;
            send_packet(flag, seq, plen, 1'b0);
         end else if (pick < 78) begin
            send_packet(16'($urandom_range(3, 65535)), $urandom, plen, 1'b0);
         end else if (pick < 84) begin
            send_header(16'($urandom), $urandom, 16'($urandom),
                        16'($urandom_range(0, HEADER_BYTES - 1)));
         end else if (pick < 90) begin
            plen = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 65535);
            send_header(16'($urandom_range(0, 3)), $urandom, 16'(plen),
                        16'($urandom_range(HEADER_BYTES, (HEADER_BYTES + plen - 1 > 65535) ?
                                                        65535 : HEADER_BYTES + plen - 1)));
         end else begin
            send_byte(8'($urandom));
         end
      end
   endtask

   task automatic test_receiver_holdoff();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      if (!rx_started) send_packet(STATUS_START, $urandom, 0, 1'b0);
      @(posedge clock);
      holdoff_left = 400;
      repeat (20) send_packet(STATUS_PROGRESS, rx_expected, 0, 1'b0);
      repeat (10) send_packet(STATUS_FIN, rx_expected, 0, 1'b0);
   endtask

   initial begin
      rx_limit     = FILE_LIMIT_RESET;
      clear_transfer();
      rx_remaining = '0;
      rx_append    = 1'b0;
      rx_verdict   = VERDICT_START;
      rx_seq       = '0;
      rx_fin       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_file_limit();

      sender_idle_pct   = 12;
      receiver_idle_pct = 78;
      csr_write_limit(20'd60);
      test_random_transfers(580);

      sender_idle_pct   = 78;
      receiver_idle_pct = 12;
      csr_write_limit(20'hFFFFF);
      test_random_transfers(580);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      csr_write_limit(20'd150);
      test_random_transfers(580);

      test_receiver_holdoff();

      idle_request();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
